>>> hw/rtl/urc_pkg.sv
package urc_pkg;

  // Field widths fixed by the sensor interface.
  localparam int unsigned TENTHS_W = 10;
  localparam int unsigned CFG_MS_W = 8;
  localparam int unsigned TRIG_CNT_W = 8;

  // Configuration port geometry: six 32-bit registers at byte offsets 4*i.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_US = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_TENTHS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELIEF_TENTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TENTHS = 3'd5;

  localparam logic [CFG_MS_W-1:0] RST_INTERVAL_MS = 8'd20;
  localparam logic [CFG_MS_W-1:0] RST_TIMEOUT_MS = 8'd36;
  localparam logic [TRIG_CNT_W-1:0] RST_TRIGGER_US = 8'd10;
  localparam logic [TENTHS_W-1:0] RST_NEAR_TENTHS = 10'd100;
  localparam logic [TENTHS_W-1:0] RST_RELIEF_TENTHS = 10'd150;
  localparam logic [TENTHS_W-1:0] RST_MAX_TENTHS = 10'd999;
  localparam logic [TENTHS_W-1:0] RST_DISTANCE = 10'd999;

  // Distance = floor(width * 5 / 29). Widths at or above DIST_LIMIT_US give
  // 1024 or more tenths, which always clamps. Below it, the quotient comes
  // from a multiply by ceil(2^20 * 5 / 29) and a shift by 20, exact there.
  localparam int unsigned DIST_LIMIT_US = 5940;
  localparam int unsigned DIST_LOW_W = 13;
  localparam int unsigned DIST_RECIP_W = 18;
  localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 18'd180789;
  localparam int unsigned DIST_SHIFT = 20;
  localparam int unsigned DIST_PROD_W = DIST_LOW_W + DIST_RECIP_W;
  localparam int unsigned DIST_QUOT_W = TENTHS_W + 1;
  localparam logic [DIST_QUOT_W-1:0] DIST_OVER = 11'd1024;

  typedef struct packed {
    logic [CFG_MS_W-1:0] interval_ms;
    logic [CFG_MS_W-1:0] timeout_ms;
    logic [TRIG_CNT_W-1:0] trigger_us;
    logic [TENTHS_W-1:0] near_tenths;
    logic [TENTHS_W-1:0] relief_tenths;
    logic [TENTHS_W-1:0] max_tenths;
  } urc_cfg_t;

  typedef struct packed {
    logic trigger_level;
    logic [TENTHS_W-1:0] distance_tenths;
    logic new_reading;
    logic near_alarm;
  } urc_result_t;

endpackage

>>> hw/rtl/urc_if.sv
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic ms_strobe;

  modport source (output valid, output echo_level, output ms_strobe, input ready);
  modport sink (input valid, input echo_level, input ms_strobe, output ready);
endinterface

interface urc_out_if;
  logic valid;
  logic ready;
  logic trigger_level;
  logic [urc_pkg::TENTHS_W-1:0] distance_tenths;
  logic new_reading;
  logic near_alarm;

  modport source (output valid, output trigger_level, output distance_tenths,
                  output new_reading, output near_alarm, input ready);
  modport sink (input valid, input trigger_level, input distance_tenths,
                input new_reading, input near_alarm, output ready);
endinterface

>>> hw/rtl/ultrasonic_ranging_controller_core.sv
// Ultrasonic ranging controller. Each request on the input channel is one
// microsecond tick carrying the sampled echo pin level and a flag that marks
// the last tick of a millisecond; each tick produces exactly one request on
// the output channel with the trigger pin drive, the latest distance in
// tenths of a centimeter, a new-reading flag and the proximity warning. The
// block fires a trigger pulse when no measurement is running and more than
// interval_ms milliseconds have passed since the last reading, or when more
// than timeout_ms milliseconds have passed since the last trigger, and holds
// the pulse until more than trigger_us microseconds have passed. The echo
// pulse is timed in microseconds and, on its falling edge, converted to
// floor(width * 10 / 58) tenths, clamped at max_tenths. The warning sets at
// or below near_tenths and clears above relief_tenths. Throughput is one
// tick per clock cycle while the output channel takes each result. A tick
// that is accepted sits in the input register until the engine steps it,
// which loads its result into the result register, where it is offered
// until taken. The rate is set by the per-tick state update and the
// distance multiply, both combinational between the input and result
// registers. Write the configuration registers only while no ticks are in
// flight.
module ultrasonic_ranging_controller_core #(
  parameter int unsigned ECHO_COUNT_BITS = 16,
  parameter int unsigned MS_COUNT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  urc_in_if.sink                            in_ch,
  urc_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [urc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [urc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [urc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  urc_pkg::urc_cfg_t cfg;
  urc_pkg::urc_result_t step_res;
  urc_pkg::urc_result_t out_res_r;

  // Input register: holds one accepted tick until the engine consumes it.
  logic in_valid_r;
  logic in_echo_r;
  logic in_strobe_r;
  logic out_valid_r;
  logic advance;

  // The engine steps whenever a tick is waiting and the result register is
  // free or being emptied in this same cycle, so a full pipe still moves
  // one tick per cycle while its results are taken.
  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_echo_r <= in_ch.echo_level;
      in_strobe_r <= in_ch.ms_strobe;
    end
  end

  urc_cfg_regs u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  urc_engine #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS),
    .MS_COUNT_BITS(MS_COUNT_BITS)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .step_en(advance),
    .echo_level(in_echo_r),
    .ms_strobe(in_strobe_r),
    .cfg(cfg),
    .result(step_res)
  );

  // Result register: loaded on each engine step, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.trigger_level = out_res_r.trigger_level;
  assign out_ch.distance_tenths = out_res_r.distance_tenths;
  assign out_ch.new_reading = out_res_r.new_reading;
  assign out_ch.near_alarm = out_res_r.near_alarm;

  // An engine step always leaves a result waiting in the next cycle.
  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("engine step did not load the result register");

  // The input side only stalls when both registers are full and the
  // result is not being taken.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipe");

  // A completed echo shows up as a new reading in the following result.
  a_reading_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && step_res.new_reading) |=>
      (out_valid_r && out_res_r.new_reading))
    else $error("new reading lost on its way to the result register");

endmodule

>>> hw/rtl/urc_dist_calc.sv
module urc_dist_calc #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  logic [ECHO_COUNT_BITS-1:0]    width_us,
  input  logic [urc_pkg::TENTHS_W-1:0]  max_tenths,
  output logic [urc_pkg::TENTHS_W-1:0]  distance_tenths
);

  logic [31:0] width_ext;
  logic over;
  logic [urc_pkg::DIST_PROD_W-1:0] prod;
  logic [urc_pkg::DIST_QUOT_W-1:0] quot;
  logic [urc_pkg::DIST_QUOT_W-1:0] limit;

  assign width_ext = 32'(width_us);
  assign over = width_ext >= 32'(urc_pkg::DIST_LIMIT_US);
  assign prod = urc_pkg::DIST_PROD_W'(width_ext[urc_pkg::DIST_LOW_W-1:0]) *
                urc_pkg::DIST_PROD_W'(urc_pkg::DIST_RECIP);
  assign quot = over ? urc_pkg::DIST_OVER
                     : prod[urc_pkg::DIST_PROD_W-1:urc_pkg::DIST_SHIFT];
  assign limit = {1'b0, max_tenths};

  assign distance_tenths = (quot > limit) ? max_tenths
                                          : quot[urc_pkg::TENTHS_W-1:0];

endmodule

>>> hw/rtl/urc_cfg_regs.sv
module urc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [urc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [urc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [urc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output urc_pkg::urc_cfg_t                 cfg
);

  urc_pkg::urc_cfg_t cfg_r;
  logic wr_en;
  logic [urc_pkg::CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = paddr[urc_pkg::CFG_ADDR_W-1:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_ms <= urc_pkg::RST_INTERVAL_MS;
      cfg_r.timeout_ms <= urc_pkg::RST_TIMEOUT_MS;
      cfg_r.trigger_us <= urc_pkg::RST_TRIGGER_US;
      cfg_r.near_tenths <= urc_pkg::RST_NEAR_TENTHS;
      cfg_r.relief_tenths <= urc_pkg::RST_RELIEF_TENTHS;
      cfg_r.max_tenths <= urc_pkg::RST_MAX_TENTHS;
    end else if (wr_en) begin
      unique case (idx)
        urc_pkg::REG_INTERVAL_MS: cfg_r.interval_ms <= pwdata[urc_pkg::CFG_MS_W-1:0];
        urc_pkg::REG_TIMEOUT_MS: cfg_r.timeout_ms <= pwdata[urc_pkg::CFG_MS_W-1:0];
        urc_pkg::REG_TRIGGER_US: cfg_r.trigger_us <= pwdata[urc_pkg::TRIG_CNT_W-1:0];
        urc_pkg::REG_NEAR_TENTHS: cfg_r.near_tenths <= pwdata[urc_pkg::TENTHS_W-1:0];
        urc_pkg::REG_RELIEF_TENTHS: cfg_r.relief_tenths <= pwdata[urc_pkg::TENTHS_W-1:0];
        urc_pkg::REG_MAX_TENTHS: cfg_r.max_tenths <= pwdata[urc_pkg::TENTHS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      urc_pkg::REG_INTERVAL_MS: prdata = urc_pkg::CFG_DATA_W'(cfg_r.interval_ms);
      urc_pkg::REG_TIMEOUT_MS: prdata = urc_pkg::CFG_DATA_W'(cfg_r.timeout_ms);
      urc_pkg::REG_TRIGGER_US: prdata = urc_pkg::CFG_DATA_W'(cfg_r.trigger_us);
      urc_pkg::REG_NEAR_TENTHS: prdata = urc_pkg::CFG_DATA_W'(cfg_r.near_tenths);
      urc_pkg::REG_RELIEF_TENTHS: prdata = urc_pkg::CFG_DATA_W'(cfg_r.relief_tenths);
      urc_pkg::REG_MAX_TENTHS: prdata = urc_pkg::CFG_DATA_W'(cfg_r.max_tenths);
      default: prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/urc_engine.sv
module urc_engine #(
  parameter int unsigned ECHO_COUNT_BITS = 16,
  parameter int unsigned MS_COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic                   echo_level,
  input  logic                   ms_strobe,
  input  urc_pkg::urc_cfg_t      cfg,
  output urc_pkg::urc_result_t   result
);

  localparam int unsigned CMP_W =
    (MS_COUNT_BITS > urc_pkg::CFG_MS_W) ? MS_COUNT_BITS : urc_pkg::CFG_MS_W;
  localparam logic [MS_COUNT_BITS-1:0] MS_MAX = '1;
  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;
  localparam logic [urc_pkg::TRIG_CNT_W-1:0] TRIG_MAX = '1;

  logic measuring_r, measuring_nxt;
  logic trig_active_r, trig_active_nxt;
  logic [urc_pkg::TRIG_CNT_W-1:0] trig_cnt_r, trig_cnt_nxt;
  logic [MS_COUNT_BITS-1:0] ms_reading_r, ms_reading_nxt;
  logic [MS_COUNT_BITS-1:0] ms_trigger_r, ms_trigger_nxt;
  logic echo_prev_r;
  logic [ECHO_COUNT_BITS-1:0] width_r, width_nxt;
  logic [urc_pkg::TENTHS_W-1:0] dist_r, dist_nxt;
  logic warn_r, warn_nxt;

  logic [ECHO_COUNT_BITS-1:0] width_inc;
  logic [urc_pkg::TENTHS_W-1:0] dist_calc;
  logic rise, fall, start;

  assign width_inc = (width_r == ECHO_MAX) ? width_r : width_r + 1'b1;
  assign rise = echo_level && !echo_prev_r;
  assign fall = !echo_level && echo_prev_r;

  urc_dist_calc #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_dist (
    .width_us(width_inc),
    .max_tenths(cfg.max_tenths),
    .distance_tenths(dist_calc)
  );

  always_comb begin
    ms_reading_nxt = ms_reading_r;
    ms_trigger_nxt = ms_trigger_r;
    measuring_nxt = measuring_r;
    trig_active_nxt = trig_active_r;
    trig_cnt_nxt = trig_cnt_r;
    width_nxt = width_r;
    dist_nxt = dist_r;
    warn_nxt = warn_r;

    if (ms_strobe) begin
      if (ms_reading_r != MS_MAX) ms_reading_nxt = ms_reading_r + 1'b1;
      if (ms_trigger_r != MS_MAX) ms_trigger_nxt = ms_trigger_r + 1'b1;
    end

    if (rise) begin
      width_nxt = '0;
    end else if (echo_level || echo_prev_r) begin
      width_nxt = width_inc;
      if (fall) begin
        dist_nxt = dist_calc;
        measuring_nxt = 1'b0;
        ms_reading_nxt = '0;
        if (dist_calc <= cfg.near_tenths) begin
          warn_nxt = 1'b1;
        end else if (warn_r && dist_calc > cfg.relief_tenths) begin
          warn_nxt = 1'b0;
        end
      end
    end

    start = (!measuring_nxt && CMP_W'(ms_reading_nxt) > CMP_W'(cfg.interval_ms)) ||
            (CMP_W'(ms_trigger_nxt) > CMP_W'(cfg.timeout_ms));

    if (start) begin
      measuring_nxt = 1'b1;
      trig_active_nxt = 1'b1;
      trig_cnt_nxt = '0;
      ms_trigger_nxt = '0;
    end else if (trig_active_r) begin
      if (trig_cnt_r != TRIG_MAX) trig_cnt_nxt = trig_cnt_r + 1'b1;
      if (trig_cnt_nxt > cfg.trigger_us) trig_active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measuring_r <= 1'b0;
      trig_active_r <= 1'b0;
      trig_cnt_r <= '0;
      ms_reading_r <= MS_MAX;
      ms_trigger_r <= '0;
      echo_prev_r <= 1'b0;
      width_r <= '0;
      dist_r <= urc_pkg::RST_DISTANCE;
      warn_r <= 1'b0;
    end else if (step_en) begin
      measuring_r <= measuring_nxt;
      trig_active_r <= trig_active_nxt;
      trig_cnt_r <= trig_cnt_nxt;
      ms_reading_r <= ms_reading_nxt;
      ms_trigger_r <= ms_trigger_nxt;
      echo_prev_r <= echo_level;
      width_r <= width_nxt;
      dist_r <= dist_nxt;
      warn_r <= warn_nxt;
    end
  end

  assign result.trigger_level = trig_active_nxt;
  assign result.distance_tenths = dist_nxt;
  assign result.new_reading = fall;
  assign result.near_alarm = warn_nxt;

endmodule
